### hw/rtl/mli_pkg.sv
// ----------------------------------------------------------------------------
// Multi-axis linear interpolator package
// Shared codes, widths, home positions and the structs that run between
// the lanes, the merge stage and the output buffer.
// ----------------------------------------------------------------------------
package mli_pkg;

   // Number of axis slots in a result frame and widths of the fixed fields.
   localparam int SLOTS      = 7;
   localparam int OUT_POS_W  = 10;
   localparam int TGT_W      = 10;
   localparam int NODE_W     = 11;
   localparam int OPCODE_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // Opcodes of an input beat.
   localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_HOME = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_ID   = 1'd1;

   // Move modes.
   localparam logic MODE_EVEN  = 1'b0;
   localparam logic MODE_FIXED = 1'b1;

   // Axis direction codes.
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // Home position of each axis slot.
   localparam logic [OUT_POS_W-1:0] HOME_POS [SLOTS] = '{
      10'd150, 10'd50, 10'd150, 10'd125, 10'd250, 10'd135, 10'd18
   };

   // Per-beat command from the merge stage to every lane.
   typedef struct packed {
      logic latch_target;
      logic latch_home;
      logic step_even;
      logic final_even;
      logic step_fixed;
   } lane_cmd_type;

   // One result frame as it sits in the output buffer.
   typedef struct packed {
      logic [NODE_W-1:0]                frame_node;
      logic [SLOTS-1:0][OUT_POS_W-1:0]  position;
      logic                             last;
   } frame_type;

endpackage

### hw/rtl/mli_lane.sv
// ----------------------------------------------------------------------------
// Interpolator axis lane
// Holds the position, goal and DDA accumulators of one axis and advances
// them on each command from the merge stage.
// ----------------------------------------------------------------------------
module mli_lane
   import mli_pkg::*;
#(
   parameter int POS_BITS = 10,
   parameter int LANE_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_cmd_type        cmd,
   input  logic [TGT_W-1:0]    target,
   input  logic [POS_BITS-1:0] largest_span,
   output logic [POS_BITS-1:0] span_new,
   output logic                settled,
   output logic [POS_BITS-1:0] position_next
);

   localparam int ACC_BITS = 2 * POS_BITS;
   localparam logic [POS_BITS-1:0] HOME = POS_BITS'(HOME_POS[LANE_IDX]);

   logic [POS_BITS-1:0] position_ff, position_in;
   logic [POS_BITS-1:0] goal_ff, goal_in;
   logic [1:0]          direction_ff, direction_in;
   logic [POS_BITS-1:0] span_ff, span_in;
   logic [ACC_BITS-1:0] step_acc_ff, step_acc_in;
   logic [ACC_BITS-1:0] tick_acc_ff, tick_acc_in;

   logic [POS_BITS-1:0] goal_new;
   logic                up_new;
   logic                down_new;
   logic                can_step;

   // New goal and its distance from the present position.
   assign goal_new = cmd.latch_home ? HOME : POS_BITS'(target);
   assign up_new   = goal_new > position_ff;
   assign down_new = goal_new < position_ff;
   assign span_new = up_new   ? (goal_new - position_ff) :
                     down_new ? (position_ff - goal_new) : '0;

   assign settled  = (position_ff == goal_ff);
   assign can_step = (direction_ff != DIR_NONE) && !settled &&
                     (step_acc_ff <= tick_acc_ff);

   // Next state of the lane.
   always_comb begin
      position_in  = position_ff;
      goal_in      = goal_ff;
      direction_in = direction_ff;
      span_in      = span_ff;
      step_acc_in  = step_acc_ff;
      tick_acc_in  = tick_acc_ff;
      if (cmd.latch_target || cmd.latch_home) begin
         goal_in      = goal_new;
         direction_in = up_new ? DIR_UP : (down_new ? DIR_DOWN : DIR_NONE);
         span_in      = span_new;
         step_acc_in  = '0;
         tick_acc_in  = '0;
      end else if (cmd.step_even) begin
         if (can_step) begin
            position_in = (direction_ff == DIR_UP) ? (position_ff + 1'b1)
                                                   : (position_ff - 1'b1);
            step_acc_in = step_acc_ff + ACC_BITS'(largest_span);
         end
         tick_acc_in = tick_acc_ff + ACC_BITS'(span_ff);
      end else if (cmd.final_even) begin
         position_in = goal_ff;
      end else if (cmd.step_fixed) begin
         if (goal_ff > position_ff) begin
            position_in = position_ff + 1'b1;
         end else if (goal_ff < position_ff) begin
            position_in = position_ff - 1'b1;
         end
      end
   end

   assign position_next = position_in;

   // Lane registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= HOME;
         goal_ff      <= HOME;
         direction_ff <= DIR_NONE;
         span_ff      <= '0;
         step_acc_ff  <= '0;
         tick_acc_ff  <= '0;
      end else begin
         position_ff  <= position_in;
         goal_ff      <= goal_in;
         direction_ff <= direction_in;
         span_ff      <= span_in;
         step_acc_ff  <= step_acc_in;
         tick_acc_ff  <= tick_acc_in;
      end
   end

endmodule

### hw/rtl/mli_merge.sv
// ----------------------------------------------------------------------------
// Interpolator merge stage
// Decodes each beat into a lane command, combines the lane spans into the
// largest span and the settled flags into the end-of-move decision.
// ----------------------------------------------------------------------------
module mli_merge
   import mli_pkg::*;
#(
   parameter int AXES     = 7,
   parameter int POS_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic                move_mode,
   input  logic [POS_BITS-1:0] lane_span [AXES],
   input  logic [AXES-1:0]     lane_settled,
   output lane_cmd_type        cmd,
   output logic [POS_BITS-1:0] largest_span,
   output logic                emit,
   output logic                last
);

   logic [POS_BITS-1:0] tick_index_ff, tick_index_in;
   logic [POS_BITS-1:0] largest_ff, largest_in;
   logic                moving_ff, moving_in;

   logic                latch;
   logic                tick;
   logic                even_tick;
   logic                even_done;
   logic                fixed_tick;
   logic [POS_BITS-1:0] span_max;

   // Beat decode.
   assign latch      = accept && ((opcode == OP_SET) || (opcode == OP_HOME));
   assign tick       = accept && (opcode == OP_TICK) && moving_ff;
   assign even_tick  = tick && (move_mode == MODE_EVEN);
   assign fixed_tick = tick && (move_mode == MODE_FIXED);
   assign even_done  = (tick_index_ff >= largest_ff);

   always_comb begin
      cmd.latch_target = accept && (opcode == OP_SET);
      cmd.latch_home   = accept && (opcode == OP_HOME);
      cmd.step_even    = even_tick && !even_done;
      cmd.final_even   = even_tick && even_done;
      cmd.step_fixed   = fixed_tick;
   end

   assign emit = tick;
   assign last = (even_tick && even_done) || (fixed_tick && (&lane_settled));
   assign largest_span = largest_ff;

   // Largest span over the lanes, taken when new goals are latched.
   always_comb begin
      span_max = '0;
      for (int j = 0; j < AXES; j++) begin
         if (lane_span[j] > span_max) begin
            span_max = lane_span[j];
         end
      end
   end

   // Move progress.
   always_comb begin
      tick_index_in = tick_index_ff;
      largest_in    = largest_ff;
      moving_in     = moving_ff;
      if (latch) begin
         tick_index_in = '0;
         largest_in    = span_max;
         moving_in     = 1'b1;
      end else if (tick) begin
         if (cmd.step_even) begin
            tick_index_in = tick_index_ff + 1'b1;
         end
         if (last) begin
            moving_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_index_ff <= '0;
         largest_ff    <= '0;
         moving_ff     <= 1'b0;
      end else begin
         tick_index_ff <= tick_index_in;
         largest_ff    <= largest_in;
         moving_ff     <= moving_in;
      end
   end

endmodule

### hw/rtl/mli_outbuf.sv
// ----------------------------------------------------------------------------
// Interpolator output buffer
// Output register with a skid stage, so that one more beat can be taken
// while a frame waits on a stalled receiver.
// ----------------------------------------------------------------------------
module mli_outbuf
   import mli_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  frame_type in_frame,
   output logic      full,
   output logic      out_valid,
   input  logic      out_stall,
   output frame_type out_frame
);

   logic      main_valid_ff, main_valid_in;
   frame_type main_frame_ff, main_frame_in;
   logic      skid_valid_ff, skid_valid_in;
   frame_type skid_frame_ff, skid_frame_in;
   logic      drain;

   // The output register moves on when it is empty or its beat is taken.
   assign drain = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_frame_in = main_frame_ff;
      skid_valid_in = skid_valid_ff;
      skid_frame_in = skid_frame_ff;
      if (drain) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_frame_in = skid_frame_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_frame_in = in_frame;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_frame_in = in_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_frame_ff <= main_frame_in;
      skid_frame_ff <= skid_frame_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_frame = main_frame_ff;

endmodule

### hw/rtl/multi_axis_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Multi-axis linear interpolator
// Moves up to seven axis positions toward latched goals, one unit per tick,
// in an even-velocity DDA mode or a fixed single-step mode.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one beat per command: a tick, a set-target with
//   seven goals, or a go-home. Set-target and home beats latch new goals from
//   the current positions and produce nothing. A tick during an active move
//   produces one rsp_ beat with the node id and all positions; rsp_last marks
//   the frame that ends the move. Ticks outside a move produce nothing.
//   The csr_ channel writes move_mode (index 0) and node_id (index 1); it is
//   always ready. It must be written only while the block is idle; the
//   block itself does not enforce this. The frame of an accepted tick is
//   registered. One beat is taken every cycle while req_stall is low: each
//   axis lane updates with one add and compare on its accumulators.
//   When the receiver stalls, the waiting frame holds and one further beat
//   is caught in a skid register; req_stall rises only once that is full.
//   Reset puts every axis at its home position with no move in progress,
//   move_mode at even velocity and node_id at zero.
// ----------------------------------------------------------------------------
module multi_axis_linear_interpolator
   import mli_pkg::*;
#(
   parameter int AXES     = 7,
   parameter int POS_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [TGT_W-1:0]      req_target0,
   input  logic [TGT_W-1:0]      req_target1,
   input  logic [TGT_W-1:0]      req_target2,
   input  logic [TGT_W-1:0]      req_target3,
   input  logic [TGT_W-1:0]      req_target4,
   input  logic [TGT_W-1:0]      req_target5,
   input  logic [TGT_W-1:0]      req_target6,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [NODE_W-1:0]     rsp_frame_node,
   output logic [OUT_POS_W-1:0]  rsp_position0,
   output logic [OUT_POS_W-1:0]  rsp_position1,
   output logic [OUT_POS_W-1:0]  rsp_position2,
   output logic [OUT_POS_W-1:0]  rsp_position3,
   output logic [OUT_POS_W-1:0]  rsp_position4,
   output logic [OUT_POS_W-1:0]  rsp_position5,
   output logic [OUT_POS_W-1:0]  rsp_position6,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                move_mode_ff, move_mode_in;
   logic [NODE_W-1:0]   node_id_ff, node_id_in;

   logic                accept;
   logic [TGT_W-1:0]    target_all [SLOTS];
   lane_cmd_type        cmd;
   logic [POS_BITS-1:0] largest_span;
   logic [POS_BITS-1:0] lane_span [AXES];
   logic [AXES-1:0]     lane_settled;
   logic [POS_BITS-1:0] lane_pos_next [AXES];
   logic                emit;
   logic                last;
   logic [SLOTS-1:0][OUT_POS_W-1:0] frame_pos;
   frame_type           frame_new;
   frame_type           frame_out;
   logic                buf_full;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      move_mode_in = move_mode_ff;
      node_id_in   = node_id_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MOVE_MODE: move_mode_in = csr_wdata[0];
            REG_NODE_ID:   node_id_in   = NODE_W'(csr_wdata);
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         move_mode_ff <= MODE_EVEN;
         node_id_ff   <= '0;
      end else begin
         move_mode_ff <= move_mode_in;
         node_id_ff   <= node_id_in;
      end
   end

   // Input handshake.
   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   assign target_all[0] = req_target0;
   assign target_all[1] = req_target1;
   assign target_all[2] = req_target2;
   assign target_all[3] = req_target3;
   assign target_all[4] = req_target4;
   assign target_all[5] = req_target5;
   assign target_all[6] = req_target6;

   // Beat decode and merging of the lane results.
   mli_merge #(
      .AXES     (AXES),
      .POS_BITS (POS_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_opcode),
      .move_mode    (move_mode_ff),
      .lane_span    (lane_span),
      .lane_settled (lane_settled),
      .cmd          (cmd),
      .largest_span (largest_span),
      .emit         (emit),
      .last         (last)
   );

   // One lane per axis; unused slots report zero.
   for (genvar j = 0; j < SLOTS; j++) begin : g_slot
      if (j < AXES) begin : g_lane
         mli_lane #(
            .POS_BITS (POS_BITS),
            .LANE_IDX (j)
         ) u_lane (
            .clock         (clock),
            .reset         (reset),
            .cmd           (cmd),
            .target        (target_all[j]),
            .largest_span  (largest_span),
            .span_new      (lane_span[j]),
            .settled       (lane_settled[j]),
            .position_next (lane_pos_next[j])
         );
         assign frame_pos[j] = OUT_POS_W'(lane_pos_next[j]);
      end else begin : g_unused
         assign frame_pos[j] = '0;
      end
   end

   always_comb begin
      frame_new.frame_node = node_id_ff;
      frame_new.position   = frame_pos;
      frame_new.last       = last;
   end

   // Output register and skid stage.
   mli_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit),
      .in_frame  (frame_new),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_frame (frame_out)
   );

   assign rsp_frame_node = frame_out.frame_node;
   assign rsp_position0  = frame_out.position[0];
   assign rsp_position1  = frame_out.position[1];
   assign rsp_position2  = frame_out.position[2];
   assign rsp_position3  = frame_out.position[3];
   assign rsp_position4  = frame_out.position[4];
   assign rsp_position5  = frame_out.position[5];
   assign rsp_position6  = frame_out.position[6];
   assign rsp_last       = frame_out.last;

endmodule
